[rtl/core/assert_macros.svh]
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/dfa_pkg.sv]
// Types and constants of the table-driven automaton matcher.
package dfa_pkg;

  localparam int NUM_STATES    = 64;
  localparam int ALPHABET_SIZE = 256;
  localparam int STATE_W       = $clog2(NUM_STATES);
  localparam int SYM_W         = 8;
  localparam int ADDR_W        = STATE_W + $clog2(ALPHABET_SIZE);
  localparam int MEM_DEPTH     = NUM_STATES * ALPHABET_SIZE;
  localparam int RES_DEPTH     = 3;
  localparam int RES_PTR_W     = $clog2(RES_DEPTH);
  localparam int RES_CNT_W     = $clog2(RES_DEPTH + 1);

  localparam logic [SYM_W-1:0] QUOTE_BYTE = 8'h22;

  typedef enum logic [1:0] {
    REQ_TRANS  = 2'd0,
    REQ_ACCEPT = 2'd1,
    REQ_CHAR   = 2'd2,
    REQ_EOS    = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [STATE_W-1:0] state_index;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] next_state;
    logic               flag;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               missing_transition;
    logic [STATE_W-1:0] final_state;
  } res_t;

  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] next_state;
  } trans_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    trans_entry_t      data;
  } mem_wr_t;

endpackage

[rtl/core/dfa_trans_mem.sv]
// Transition table memory with its clearing sweep after reset.
module dfa_trans_mem
  import dfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  mem_rd_t      rd,
  input  mem_wr_t      wr,
  output trans_entry_t rd_data,
  output logic         busy
);

  trans_entry_t      mem [MEM_DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[rtl/core/dfa_step.sv]
// Matcher state, accepting flags and the per-item table read and write control.
module dfa_step
  import dfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               clearing,
  input  logic               item_acc,
  input  req_t               item,
  input  logic [STATE_W-1:0] start_state,
  input  trans_entry_t       rd_data,
  output mem_rd_t            rd,
  output mem_wr_t            wr,
  output logic               res_push,
  output res_t               res_item
);

  logic [STATE_W-1:0] cur_state;
  logic [STATE_W-1:0] cur_state_next;
  logic               miss_seen;
  logic               miss_seen_next;
  logic               lookup;
  logic               lookup_next;
  logic               acc_mem [NUM_STATES];
  logic               acc_rd;
  logic [STATE_W-1:0] clr_index;
  logic               eos_acc;
  logic               pend;
  logic               pend_miss;
  logic [STATE_W-1:0] pend_state;
  logic [STATE_W-1:0] res_state;
  logic               res_miss;

  // The table entry read for the previous character is forwarded here.
  always_comb begin
    res_state = cur_state;
    res_miss  = miss_seen;
    if (lookup) begin
      if (rd_data.valid) begin
        res_state = rd_data.next_state;
      end else begin
        res_miss = 1'b1;
      end
    end
  end

  always_comb begin
    cur_state_next = res_state;
    miss_seen_next = res_miss;
    lookup_next    = 1'b0;
    rd             = '0;
    wr             = '0;
    eos_acc        = 1'b0;
    if (item_acc) begin
      case (item.req_type)
        REQ_TRANS: begin
          wr.en              = 1'b1;
          wr.addr            = {item.state_index, item.symbol};
          wr.data.valid      = item.flag;
          wr.data.next_state = item.next_state;
        end
        REQ_CHAR: begin
          if (item.symbol != QUOTE_BYTE && !res_miss) begin
            rd.en       = 1'b1;
            rd.addr     = {res_state, item.symbol};
            lookup_next = 1'b1;
          end
        end
        REQ_EOS: begin
          eos_acc        = 1'b1;
          cur_state_next = start_state;
          miss_seen_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      acc_mem[clr_index] <= 1'b0;
    end else if (item_acc && item.req_type == REQ_ACCEPT) begin
      acc_mem[item.state_index] <= item.flag;
    end
  end

  always_ff @(posedge clk) begin
    if (eos_acc) begin
      acc_rd <= acc_mem[res_state];
    end
  end

  assign res_push                    = pend;
  assign res_item.accepted           = !pend_miss && acc_rd;
  assign res_item.missing_transition = pend_miss;
  assign res_item.final_state        = pend_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state <= '0;
      miss_seen <= 1'b0;
      lookup    <= 1'b0;
      clr_index <= '0;
      pend      <= 1'b0;
    end else begin
      cur_state <= cur_state_next;
      miss_seen <= miss_seen_next;
      lookup    <= lookup_next;
      pend      <= eos_acc;
      if (clearing) begin
        clr_index <= clr_index + 1'b1;
      end
      if (eos_acc) begin
        pend_miss  <= res_miss;
        pend_state <= res_state;
      end
    end
  end

endmodule

[rtl/core/dfa_res_buf.sv]
// Three-entry result queue that decouples result delivery from the input side.
module dfa_res_buf
  import dfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_item,
  output logic full,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic [RES_CNT_W-1:0] count;
  logic [RES_CNT_W-1:0] count_next;
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  res_t                 slots [RES_DEPTH];
  logic                 pop;

  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != '0);
  assign res       = slots[rd_ptr];
  // An end-of-string item accepted now is registered in pend before it is pushed,
  // so a push already on its way takes up space as well.
  assign full      = (count == RES_CNT_W'(RES_DEPTH)) ||
                     (push && count == RES_CNT_W'(RES_DEPTH - 1));

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/core/dfa_string_acceptor.sv]
// Top level of the table-driven automaton matcher.
// Throughput: one item per cycle while req_stall is low; character bytes step back to back through the table.
// The result of an end-of-string item is registered in pend, then pushed into the result queue.
// The accepting flag is registered alongside pend; transition reads are forwarded to the next lookup.
// Reset clears state, then a sweep clears all 16384 table entries and the flags with stall high.
// The start state register resets to zero and may be written during the sweep.
module dfa_string_acceptor
  import dfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  output logic               res_valid,
  input  logic               res_stall,
  output res_t               res,
  input  logic               cfg_wr_en,
  input  logic [STATE_W-1:0] cfg_wr_data
);

  `include "assert_macros.svh"

  logic [STATE_W-1:0] start_state;
  logic               item_acc;
  logic               busy;
  logic               full;
  logic               res_push;
  res_t               res_item;
  mem_rd_t            rd;
  mem_wr_t            wr;
  trans_entry_t       rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
    end else if (cfg_wr_en) begin
      start_state <= cfg_wr_data;
    end
  end

  assign req_stall = busy || full;
  assign item_acc  = req_valid && !req_stall;

  dfa_trans_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data),
    .busy    (busy)
  );

  dfa_step u_step (
    .clk         (clk),
    .rst         (rst),
    .clearing    (busy),
    .item_acc    (item_acc),
    .item        (req),
    .start_state (start_state),
    .rd_data     (rd_data),
    .rd          (rd),
    .wr          (wr),
    .res_push    (res_push),
    .res_item    (res_item)
  );

  dfa_res_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_item (res_item),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  `ASSERT_IMPLIES(a_no_write_while_busy, clk, rst, busy, !rd.en && !wr.en)
  `ASSERT_NEXT(a_push_gives_valid, clk, rst, res_push, res_valid)
  `ASSERT_IMPLIES(a_accept_no_miss, clk, rst, res_valid && res.accepted, !res.missing_transition)

endmodule
